@@ rtl/vcst_pkg.sv @@
// Package for the vector clock snapshot tracker.
// Holds command, result kind and clock operation codes and fixed field widths.
// No dependencies.
`default_nettype none

package vcst_pkg;

  localparam int CMD_W    = 2;
  localparam int PEER_W   = 2;
  localparam int LAM_W    = 16;
  localparam int VEC_W    = 64;
  localparam int SNUM_W   = 3;
  localparam int KIND_W   = 2;
  localparam int MASK_W   = 8;
  localparam int ENTRY_W  = 16;
  localparam int ENTRIES  = 4;

  localparam logic [CMD_W-1:0] CMD_SEND     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECV_XFR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RECV_MRK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT     = 2'd3;

  localparam logic [KIND_W-1:0] KIND_STAMP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARKER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd2;

  // Clock unit operation: hold (stamp without advancing), send, receive merge.
  typedef enum logic [1:0] {
    CLK_HOLD,
    CLK_SEND,
    CLK_MERGE
  } clk_op_t;

  typedef struct packed {
    logic    fire;
    clk_op_t op;
  } clk_ctl_t;

endpackage

`default_nettype wire

@@ rtl/vcst_clock_unit.sv @@
// Lamport counter and vector clock registers with saturating advance and merge.
// Depends on vcst_pkg.
`default_nettype none

module vcst_clock_unit #(
  parameter int NUM_PROCS  = 4,
  parameter int CLOCK_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  vcst_pkg::clk_ctl_t          ctl,
  input  wire [1:0]                   own_id,
  input  wire [vcst_pkg::LAM_W-1:0]   recv_lamport,
  input  wire [vcst_pkg::VEC_W-1:0]   recv_vector,
  output logic [vcst_pkg::LAM_W-1:0]  lam_o,
  output logic [vcst_pkg::VEC_W-1:0]  vec_o
);
  import vcst_pkg::*;

  localparam logic [CLOCK_BITS-1:0] CMAX = '1;

  logic [CLOCK_BITS-1:0]                 lam_r, lam_nxt;
  logic [NUM_PROCS-1:0][CLOCK_BITS-1:0]  vec_r, vec_nxt;
  logic [CLOCK_BITS-1:0]                 rl_c, big, stamp;
  logic [CLOCK_BITS-1:0]                 ent;

  function automatic logic [CLOCK_BITS-1:0] sat_inc(input logic [CLOCK_BITS-1:0] v);
    sat_inc = (v == CMAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CLOCK_BITS-1:0] clamp(input logic [ENTRY_W-1:0] v);
    clamp = (v > ENTRY_W'(CMAX)) ? CMAX : CLOCK_BITS'(v);
  endfunction

  always_comb begin
    rl_c    = clamp(recv_lamport);
    big     = (rl_c > lam_r) ? rl_c : lam_r;
    stamp   = lam_r;
    lam_nxt = lam_r;
    ent     = '0;
    case (ctl.op)
      CLK_SEND: begin
        lam_nxt = sat_inc(lam_r);
      end
      CLK_MERGE: begin
        stamp   = sat_inc(big);
        lam_nxt = sat_inc(stamp);
      end
      default: begin
        lam_nxt = lam_r;
      end
    endcase

    vec_nxt = vec_r;
    for (int i = 0; i < NUM_PROCS; i++) begin
      ent = clamp(recv_vector[ENTRY_W*i +: ENTRY_W]);
      if (own_id == 2'(i)) begin
        if (ctl.op != CLK_HOLD) vec_nxt[i] = sat_inc(vec_r[i]);
      end else if (ctl.op == CLK_MERGE && ent > vec_r[i]) begin
        vec_nxt[i] = ent;
      end
    end

    lam_o = LAM_W'(stamp);
    vec_o = '0;
    for (int i = 0; i < NUM_PROCS; i++) begin
      vec_o[ENTRY_W*i +: ENTRY_W] = ENTRY_W'(vec_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= '0;
      vec_r <= '0;
    end else if (ctl.fire) begin
      lam_r <= lam_nxt;
      vec_r <= vec_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/vector_clock_snapshot_tracker_top.sv @@
// Vector clock and snapshot tracker: item register, result sequencer, result register.
// An item waits in the item register; its results pass through the result register.
// Throughput: one result per cycle while out_ready holds; an item causes 1 to
// NUM_PROCS results, one at a time through the single result register, and a dropped
// snapshot start causes none. Synchronous active-low reset clears all clocks and flags.
// Depends on vcst_pkg and vcst_clock_unit.
`default_nettype none

module vector_clock_snapshot_tracker_top #(
  parameter int NUM_PROCS  = 4,
  parameter int NUM_SNAPS  = 8,
  parameter int CLOCK_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // configuration
  input  wire                             cfg_wr_en,
  input  wire [1:0]                       cfg_wr_data,
  // input channel
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire [vcst_pkg::CMD_W-1:0]       in_command,
  input  wire [vcst_pkg::PEER_W-1:0]      in_peer,
  input  wire [vcst_pkg::LAM_W-1:0]       in_recv_lamport,
  input  wire [vcst_pkg::VEC_W-1:0]       in_recv_vector,
  input  wire [vcst_pkg::SNUM_W-1:0]      in_marker_snapshot,
  input  wire                             in_reply_wanted,
  // result channel
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [vcst_pkg::KIND_W-1:0]     out_kind,
  output logic [vcst_pkg::PEER_W-1:0]     out_dest,
  output logic [vcst_pkg::LAM_W-1:0]      out_stamp_lamport,
  output logic [vcst_pkg::VEC_W-1:0]      out_stamp_vector,
  output logic [vcst_pkg::SNUM_W-1:0]     out_snap_number,
  output logic                            out_record_local,
  output logic [vcst_pkg::MASK_W-1:0]     out_in_transit_mask,
  output logic                            out_snap_complete,
  output logic                            out_last
);
  import vcst_pkg::*;

  localparam int PW = $clog2(NUM_PROCS + 2);   // marker target counter, holds past-end
  localparam int SW = $clog2(NUM_SNAPS + 1);   // snapshots started, holds NUM_SNAPS

  // sequencer phases
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_REPLY = 2'd2;

  // configuration
  logic [1:0] own_id_r;

  // item register
  logic                item_v_r, item_v_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [PEER_W-1:0]   peer_r;
  logic [LAM_W-1:0]    rl_r;
  logic [VEC_W-1:0]    rv_r;
  logic [SNUM_W-1:0]   ms_r;
  logic                rw_r;

  // sequencer and snapshot state
  logic [1:0]                          phase_r, phase_nxt;
  logic [PW-1:0]                       mk_idx_r, mk_nxt;
  logic [SNUM_W-1:0]                   snap_r, snap_nxt;
  logic [SW-1:0]                       started_r, started_nxt;
  logic [NUM_SNAPS-1:0]                seen_r, seen_nxt;
  logic [NUM_PROCS-1:0][NUM_SNAPS-1:0] rec_r, rec_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r;
  logic [PEER_W-1:0]   out_dest_r;
  logic [LAM_W-1:0]    out_lam_r;
  logic [VEC_W-1:0]    out_vec_r;
  logic [SNUM_W-1:0]   out_snap_r;
  logic                out_rec_r;
  logic [MASK_W-1:0]   out_mask_r;
  logic                out_cmpl_r;
  logic                out_last_r;

  // sequencer outputs
  logic                accept, out_free, fire, drop, emit, last, done;
  logic [KIND_W-1:0]   r_kind;
  logic [PEER_W-1:0]   r_dest;
  logic [SNUM_W-1:0]   r_snap;
  logic                r_rec, r_cmpl;
  logic [MASK_W-1:0]   r_mask;
  clk_ctl_t            clk_ctl;
  clk_op_t             op;
  logic [LAM_W-1:0]    stamp_lam;
  logic [VEC_W-1:0]    stamp_vec;

  // snapshot helpers
  logic [NUM_SNAPS-1:0] ms_oh, st_oh, peer_rec;
  logic                 ms_in_range, ms_seen, still_rec;
  logic [PW-1:0]        own_ext, mk_first, mk_inc, mk_after;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign own_ext  = PW'(own_id_r);
  assign mk_first = (own_id_r == 2'd0) ? PW'(1) : '0;
  assign mk_inc   = mk_idx_r + 1'b1;
  assign mk_after = (mk_inc == own_ext) ? mk_inc + 1'b1 : mk_inc;

  assign ms_oh       = NUM_SNAPS'(1) << ms_r;
  assign st_oh       = NUM_SNAPS'(1) << started_r;
  assign ms_in_range = {1'b0, ms_r} < (SNUM_W+1)'(NUM_SNAPS);
  assign ms_seen     = |(seen_r & ms_oh);

  // recording bits of the source channel; peers beyond NUM_PROCS never record
  always_comb begin
    peer_rec = '0;
    for (int i = 0; i < NUM_PROCS; i++) begin
      if (peer_r == PEER_W'(i)) peer_rec = rec_r[i];
    end
  end

  // Sequencer: one result per fire, none for a dropped snapshot start. The first phase
  // handles the item's own event; marker and reply phases each stamp one outgoing send.
  always_comb begin
    op          = CLK_HOLD;
    drop        = 1'b0;
    last        = 1'b0;
    r_kind      = KIND_STAMP;
    r_dest      = '0;
    r_snap      = '0;
    r_rec       = 1'b0;
    r_mask      = '0;
    r_cmpl      = 1'b0;
    still_rec   = 1'b0;
    phase_nxt   = phase_r;
    mk_nxt      = mk_idx_r;
    snap_nxt    = snap_r;
    started_nxt = started_r;
    seen_nxt    = seen_r;
    rec_nxt     = rec_r;

    case (phase_r)
      PH_FIRST: begin
        case (cmd_r)
          CMD_SEND: begin
            op     = CLK_SEND;
            r_dest = peer_r;
            last   = 1'b1;
          end
          CMD_RECV_XFR: begin
            op     = CLK_MERGE;
            r_mask = MASK_W'(peer_rec);
            last   = !rw_r;
            if (rw_r) phase_nxt = PH_REPLY;
          end
          CMD_RECV_MRK: begin
            op     = CLK_MERGE;
            r_snap = ms_r;
            if (!ms_in_range) begin
              last = 1'b1;
            end else if (!ms_seen) begin
              // first marker: record local state, start recording the other channels
              seen_nxt = seen_r | ms_oh;
              for (int i = 0; i < NUM_PROCS; i++) begin
                if (own_id_r != 2'(i) && peer_r != PEER_W'(i)) begin
                  rec_nxt[i] = rec_r[i] | ms_oh;
                end
              end
              r_rec     = 1'b1;
              phase_nxt = PH_MARK;
              mk_nxt    = mk_first;
              snap_nxt  = ms_r;
            end else begin
              // repeat marker: stop the source channel
              for (int i = 0; i < NUM_PROCS; i++) begin
                if (peer_r == PEER_W'(i)) rec_nxt[i] = rec_r[i] & ~ms_oh;
              end
              last = 1'b1;
            end
            for (int i = 0; i < NUM_PROCS; i++) begin
              still_rec = still_rec | (|(rec_nxt[i] & ms_oh));
            end
            r_cmpl = ms_in_range && !still_rec;
          end
          default: begin
            if (started_r >= SW'(NUM_SNAPS)) begin
              drop = 1'b1;
            end else begin
              r_snap      = SNUM_W'(started_r);
              r_rec       = 1'b1;
              started_nxt = started_r + 1'b1;
              seen_nxt    = seen_r | st_oh;
              for (int i = 0; i < NUM_PROCS; i++) begin
                if (own_id_r != 2'(i)) rec_nxt[i] = rec_r[i] | st_oh;
              end
              phase_nxt = PH_MARK;
              mk_nxt    = mk_first;
              snap_nxt  = SNUM_W'(started_r);
            end
          end
        endcase
      end
      PH_MARK: begin
        op     = CLK_SEND;
        r_kind = KIND_MARKER;
        r_dest = PEER_W'(mk_idx_r);
        r_snap = snap_r;
        mk_nxt = mk_after;
        last   = mk_after >= PW'(NUM_PROCS);
      end
      PH_REPLY: begin
        op     = CLK_SEND;
        r_kind = KIND_REPLY;
        r_dest = peer_r;
        last   = 1'b1;
      end
      default: begin
        drop = 1'b1;
      end
    endcase
    if (last || drop) phase_nxt = PH_FIRST;
  end

  assign fire     = item_v_r && (drop || out_free);
  assign emit     = fire && !drop;
  assign done     = fire && (drop || last);
  assign in_ready = !item_v_r || done;

  assign clk_ctl.fire = emit;
  assign clk_ctl.op   = op;

  vcst_clock_unit #(
    .NUM_PROCS  (NUM_PROCS),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_clock (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (clk_ctl),
    .own_id       (own_id_r),
    .recv_lamport (rl_r),
    .recv_vector  (rv_r),
    .lam_o        (stamp_lam),
    .vec_o        (stamp_vec)
  );

  always_comb begin
    item_v_nxt = item_v_r;
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (done) begin
      item_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= '0;
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIRST;
      mk_idx_r    <= '0;
      snap_r      <= '0;
      started_r   <= '0;
      seen_r      <= '0;
      rec_r       <= '0;
    end else begin
      if (cfg_wr_en) own_id_r <= cfg_wr_data;
      item_v_r    <= item_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r   <= phase_nxt;
        mk_idx_r  <= mk_nxt;
        snap_r    <= snap_nxt;
        started_r <= started_nxt;
        seen_r    <= seen_nxt;
        rec_r     <= rec_nxt;
      end
    end
  end

  // payload: hold item until its last result, load result on emit
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      peer_r <= in_peer;
      rl_r   <= in_recv_lamport;
      rv_r   <= in_recv_vector;
      ms_r   <= in_marker_snapshot;
      rw_r   <= in_reply_wanted;
    end
    if (emit) begin
      out_kind_r <= r_kind;
      out_dest_r <= r_dest;
      out_lam_r  <= stamp_lam;
      out_vec_r  <= stamp_vec;
      out_snap_r <= r_snap;
      out_rec_r  <= r_rec;
      out_mask_r <= r_mask;
      out_cmpl_r <= r_cmpl;
      out_last_r <= last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_dest            = out_dest_r;
  assign out_stamp_lamport   = out_lam_r;
  assign out_stamp_vector    = out_vec_r;
  assign out_snap_number     = out_snap_r;
  assign out_record_local    = out_rec_r;
  assign out_in_transit_mask = out_mask_r;
  assign out_snap_complete   = out_cmpl_r;
  assign out_last            = out_last_r;

  // A marker or reply phase only runs while an item is held.
  a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FIRST) |-> item_v_r)
    else $error("sequencer phase active without a held item");

  // A marker never goes to this process itself.
  a_marker_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_MARKER) |-> (out_dest_r != own_id_r))
    else $error("marker addressed to own process");

  // Snapshot starts never pass the number of snapshot slots.
  a_started_bound: assert property (@(posedge clk) disable iff (!rst_n)
    started_r <= SW'(NUM_SNAPS))
    else $error("snapshot start count out of range");

  // Every emitted result lands in the result register.
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted result lost");

endmodule

`default_nettype wire

@@ bench/vector_clock_snapshot_tracker_top_tb.sv @@
// Self-checking bench for vector_clock_snapshot_tracker_top: directed events, back-pressure,
// random event mixes under several process ids, snapshot exhaustion and counter saturation.
// Depends on vcst_pkg and the tracker RTL only.
module vector_clock_snapshot_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcst_pkg::*;

  localparam int SNAP_SLOTS      = 8;
  localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES   = 4;     // covers a dropped snapshot start still in flight
  localparam int PRESSURE_CYCLES = 300;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PEER_W-1:0] dest;
    logic [LAM_W-1:0]  lam;
    logic [VEC_W-1:0]  vec;
    logic [SNUM_W-1:0] snap;
    logic              rec;
    logic [MASK_W-1:0] mask;
    logic              done;
    logic              last;
  } stamp_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [1:0]          cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = CMD_SEND;
  logic [PEER_W-1:0]   in_peer = '0;
  logic [LAM_W-1:0]    in_recv_lamport = '0;
  logic [VEC_W-1:0]    in_recv_vector = '0;
  logic [SNUM_W-1:0]   in_marker_snapshot = '0;
  logic                in_reply_wanted = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [PEER_W-1:0]   out_dest;
  logic [LAM_W-1:0]    out_stamp_lamport;
  logic [VEC_W-1:0]    out_stamp_vector;
  logic [SNUM_W-1:0]   out_snap_number;
  logic                out_record_local;
  logic [MASK_W-1:0]   out_in_transit_mask;
  logic                out_snap_complete;
  logic                out_last;

  // Tracker state as the bench believes it to be.
  logic [1:0]          proc_id = '0;
  logic [LAM_W-1:0]    next_lam = '0;
  logic [ENTRY_W-1:0]  vclock [ENTRIES] = '{default: '0};
  logic [SNAP_SLOTS-1:0] seen_snaps = '0;
  logic [MASK_W-1:0]   chan_rec [ENTRIES] = '{default: '0};
  int                  snaps_begun = 0;

  stamp_t              stamp_q[$];      // results still owed by the tracker, oldest first
  int                  err_count = 0;
  int                  quiet_cycles = 0;
  int                  hold_left = 0;   // receiver back-pressure cycles still to go
  logic                sender_idle = 1'b1;
  logic                receiver_idle = 1'b1;

  vector_clock_snapshot_tracker_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_peer             (in_peer),
    .in_recv_lamport     (in_recv_lamport),
    .in_recv_vector      (in_recv_vector),
    .in_marker_snapshot  (in_marker_snapshot),
    .in_reply_wanted     (in_reply_wanted),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_dest            (out_dest),
    .out_stamp_lamport   (out_stamp_lamport),
    .out_stamp_vector    (out_stamp_vector),
    .out_snap_number     (out_snap_number),
    .out_record_local    (out_record_local),
    .out_in_transit_mask (out_in_transit_mask),
    .out_snap_complete   (out_snap_complete),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Clock and snapshot prediction
  // ---------------------------------------------------------------------------

  // Counters stick at all ones instead of wrapping.
  function automatic logic [ENTRY_W-1:0] sat_up(input logic [ENTRY_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Queue one result; the vector field is the clock as it stands right now.
  function automatic void push_stamp(input logic [KIND_W-1:0] kind, input logic [PEER_W-1:0] dest,
                                     input logic [LAM_W-1:0] lam, input logic [SNUM_W-1:0] snap,
                                     input logic rec, input logic [MASK_W-1:0] mask,
                                     input logic done);
    stamp_t s;
    s.kind = kind;
    s.dest = dest;
    s.lam  = lam;
    s.vec  = {vclock[3], vclock[2], vclock[1], vclock[0]};
    s.snap = snap;
    s.rec  = rec;
    s.mask = mask;
    s.done = done;
    s.last = 1'b0;
    stamp_q.push_back(s);
  endfunction

  // Stamp an outgoing message: hand out the current Lamport value, then advance.
  function automatic logic [LAM_W-1:0] take_send_stamp();
    logic [LAM_W-1:0] lam;
    lam = next_lam;
    next_lam = sat_up(next_lam);
    vclock[proc_id] = sat_up(vclock[proc_id]);
    return lam;
  endfunction

  // Receive: Lamport jumps past both clocks, the foreign entries take the max.
  function automatic logic [LAM_W-1:0] merge_clock(input logic [LAM_W-1:0] rl,
                                                   input logic [VEC_W-1:0] rv);
    logic [LAM_W-1:0]   lam;
    logic [ENTRY_W-1:0] e;
    int                 i;
    lam = sat_up((rl > next_lam) ? rl : next_lam);
    next_lam = sat_up(lam);
    for (i = 0; i < ENTRIES; i++) begin
      if (i != proc_id) begin
        e = rv[ENTRY_W*i +: ENTRY_W];
        if (e > vclock[i]) vclock[i] = e;
      end
    end
    vclock[proc_id] = sat_up(vclock[proc_id]);
    return lam;
  endfunction

  // One marker to every other process, each one a send of its own.
  function automatic void broadcast_markers(input logic [SNUM_W-1:0] snap);
    logic [LAM_W-1:0] lam;
    int               i;
    for (i = 0; i < ENTRIES; i++) begin
      if (i != proc_id) begin
        lam = take_send_stamp();
        push_stamp(KIND_MARKER, PEER_W'(i), lam, snap, 1'b0, '0, 1'b0);
      end
    end
  endfunction

  function automatic logic snap_closed(input logic [SNUM_W-1:0] snap);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (chan_rec[i][snap]) return 1'b0;
    return 1'b1;
  endfunction

  // Work out every result that one accepted event owes, and update the state.
  function automatic void predict_event(input logic [CMD_W-1:0] cmd, input logic [PEER_W-1:0] peer,
                                        input logic [LAM_W-1:0] rl, input logic [VEC_W-1:0] rv,
                                        input logic [SNUM_W-1:0] ms, input logic rw);
    logic [LAM_W-1:0]  lam;
    logic [SNUM_W-1:0] snap;
    stamp_t            tail;
    int                base;
    int                i;
    base = stamp_q.size();
    case (cmd)
      CMD_SEND: begin
        lam = take_send_stamp();
        push_stamp(KIND_STAMP, peer, lam, '0, 1'b0, '0, 1'b0);
      end
      CMD_RECV_XFR: begin
        lam = merge_clock(rl, rv);
        push_stamp(KIND_STAMP, '0, lam, '0, 1'b0, chan_rec[peer], 1'b0);
        if (rw) begin
          lam = take_send_stamp();
          push_stamp(KIND_REPLY, peer, lam, '0, 1'b0, '0, 1'b0);
        end
      end
      CMD_RECV_MRK: begin
        lam = merge_clock(rl, rv);
        if (!seen_snaps[ms]) begin
          // First marker: record every other incoming channel, then pass markers on.
          seen_snaps[ms] = 1'b1;
          for (i = 0; i < ENTRIES; i++)
            if (i != proc_id && i != peer) chan_rec[i][ms] = 1'b1;
          push_stamp(KIND_STAMP, '0, lam, ms, 1'b1, '0, snap_closed(ms));
          broadcast_markers(ms);
        end else begin
          chan_rec[peer][ms] = 1'b0;
          push_stamp(KIND_STAMP, '0, lam, ms, 1'b0, '0, snap_closed(ms));
        end
      end
      default: begin
        // Snapshot start; dropped silently once every slot has been used.
        if (snaps_begun < SNAP_SLOTS) begin
          snap = SNUM_W'(snaps_begun);
          snaps_begun++;
          push_stamp(KIND_STAMP, '0, next_lam, snap, 1'b1, '0, 1'b0);
          broadcast_markers(snap);
          seen_snaps[snap] = 1'b1;
          for (i = 0; i < ENTRIES; i++)
            if (i != proc_id) chan_rec[i][snap] = 1'b1;
        end
      end
    endcase
    if (stamp_q.size() > base) begin
      tail = stamp_q.pop_back();
      tail.last = 1'b1;
      stamp_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: back-pressure, checking, watchdog
  // ---------------------------------------------------------------------------

  // Drop ready for a requested stretch, otherwise stall at random when enabled.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (receiver_idle) begin
      out_ready <= ($urandom_range(0, 99) >= 29);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk) begin : check_results
    stamp_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (stamp_q.size() == 0) begin
        $display("%0t: result transfer with nothing owed (kind %0h, lamport %0h)",
                 $time, out_kind, out_stamp_lamport);
        err_count++;
      end else begin
        want = stamp_q.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_kind));
        check_field("dest", 64'(want.dest), 64'(out_dest));
        check_field("stamp_lamport", 64'(want.lam), 64'(out_stamp_lamport));
        check_field("stamp_vector", want.vec, out_stamp_vector);
        check_field("snap_number", 64'(want.snap), 64'(out_snap_number));
        check_field("record_local", 64'(want.rec), 64'(out_record_local));
        check_field("in_transit_mask", 64'(want.mask), 64'(out_in_transit_mask));
        check_field("snap_complete", 64'(want.done), 64'(out_snap_complete));
        check_field("last", 64'(want.last), 64'(out_last));
      end
    end
  end

  // Abort when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results owed",
               $time, quiet_cycles, stamp_q.size());
      $display("vector_clock_snapshot_tracker_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one event and hold it until the tracker takes it. Valid stays high into the
  // next event unless an idle gap is drawn.
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [PEER_W-1:0] peer,
                            input logic [LAM_W-1:0] rl, input logic [VEC_W-1:0] rv,
                            input logic [SNUM_W-1:0] ms, input logic rw);
    if (sender_idle) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_peer            <= peer;
    in_recv_lamport    <= rl;
    in_recv_vector     <= rv;
    in_marker_snapshot <= ms;
    in_reply_wanted    <= rw;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_event(cmd, peer, rl, rv, ms, rw);
  endtask

  // Stop offering, let every owed result drain, then give a dropped start time to finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_proc_id(input logic [1:0] id);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    proc_id      = id;
  endtask

  // A received clock value close to ours, so merges go either way; now and then far below.
  function automatic logic [LAM_W-1:0] near_clock(input logic [LAM_W-1:0] base);
    int t;
    case ($urandom_range(0, 9))
      0:       t = 0;
      1:       t = int'($urandom_range(0, base));
      default: t = int'(base) + int'($urandom_range(0, 8)) - 3;
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return LAM_W'(t);
  endfunction

  // Random events. Most markers are steered at a channel that is still recording, so
  // snapshots get driven all the way to completion; the rest land anywhere.
  task automatic run_random(input int count);
    logic [CMD_W-1:0]   cmd;
    logic [PEER_W-1:0]  peer;
    logic [PEER_W-1:0]  p;
    logic [SNUM_W-1:0]  ms;
    logic [SNUM_W-1:0]  t;
    logic [LAM_W-1:0]   rl;
    logic [VEC_W-1:0]   rv;
    logic               found;
    int                 roll;
    int                 n;
    int                 k;
    for (n = 0; n < count; n++) begin
      roll = int'($urandom_range(0, 99));
      peer = PEER_W'($urandom_range(0, 3));
      ms   = SNUM_W'($urandom_range(0, 7));
      if (roll < 35)      cmd = CMD_SEND;
      else if (roll < 70) cmd = CMD_RECV_XFR;
      else if (roll < 96) cmd = CMD_RECV_MRK;
      else                cmd = CMD_INIT;
      if (cmd == CMD_SEND || cmd == CMD_INIT) begin
        // clock fields are ignored here: fill them with anything
        rl = LAM_W'($urandom);
        rv = {$urandom, $urandom};
      end else begin
        rl = near_clock(next_lam);
        for (k = 0; k < ENTRIES; k++)
          rv[ENTRY_W*k +: ENTRY_W] = (k == proc_id) ? ENTRY_W'($urandom)
                                                    : near_clock(vclock[k]);
      end
      if (cmd == CMD_RECV_MRK && $urandom_range(0, 99) < 70) begin
        found = 1'b0;
        for (k = 0; k < SNAP_SLOTS; k++) begin
          t = SNUM_W'(ms + k);
          if (!found && (chan_rec[0][t] | chan_rec[1][t] | chan_rec[2][t] | chan_rec[3][t]))
          begin
            ms = t;
            found = 1'b1;
          end
        end
        found = 1'b0;
        for (k = 0; k < ENTRIES; k++) begin
          p = PEER_W'(peer + k);
          if (!found && chan_rec[p][ms]) begin
            peer = p;
            found = 1'b1;
          end
        end
      end
      send_event(cmd, peer, rl, rv, ms, 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command, field extremes, a full initiated snapshot and two marker-started ones.
  task automatic test_directed_events();
    set_proc_id(2'd3);
    // sends: ignored fields at their maximum, then destination equal to our own id
    send_event(CMD_SEND, 2'd0, '1, '1, 3'd7, 1'b1);
    send_event(CMD_SEND, 2'd3, '0, '0, 3'd0, 1'b0);
    // receives: one below our clock, one above it with a reply
    send_event(CMD_RECV_XFR, 2'd1, 16'd0, '0, 3'd0, 1'b0);
    send_event(CMD_RECV_XFR, 2'd2, 16'd100, {16'd4000, 16'd30, 16'd20, 16'd10}, 3'd0, 1'b1);
    // initiate snapshot 0, catch one transfer in flight, close with three markers
    send_event(CMD_INIT, 2'd0, '0, '0, 3'd0, 1'b0);
    send_event(CMD_RECV_XFR, 2'd1, 16'd110, {16'd0, 16'd5, 16'd40, 16'd12}, 3'd0, 1'b1);
    send_event(CMD_RECV_MRK, 2'd0, 16'd115, {16'd0, 16'd5, 16'd40, 16'd14}, 3'd0, 1'b0);
    send_event(CMD_RECV_MRK, 2'd1, 16'd116, {16'd0, 16'd6, 16'd41, 16'd14}, 3'd0, 1'b0);
    send_event(CMD_RECV_MRK, 2'd2, 16'd117, {16'd0, 16'd22, 16'd41, 16'd14}, 3'd0, 1'b0);
    // first marker of snapshot 5 from process 2, a transfer on a recording channel
    send_event(CMD_RECV_MRK, 2'd2, 16'd130, {16'd0, 16'd23, 16'd50, 16'd15}, 3'd5, 1'b0);
    send_event(CMD_RECV_XFR, 2'd0, 16'd140, {16'd0, 16'd23, 16'd50, 16'd60}, 3'd5, 1'b0);
    send_event(CMD_RECV_MRK, 2'd0, 16'd141, {16'd0, 16'd23, 16'd50, 16'd61}, 3'd5, 1'b0);
    send_event(CMD_RECV_MRK, 2'd1, 16'd142, {16'd0, 16'd24, 16'd50, 16'd61}, 3'd5, 1'b0);
    // marker for an already completed snapshot
    send_event(CMD_RECV_MRK, 2'd1, 16'd143, {16'd0, 16'd25, 16'd50, 16'd61}, 3'd5, 1'b0);
    // first marker of snapshot 6 arriving on our own channel: three channels record
    send_event(CMD_RECV_MRK, 2'd3, 16'd150, '0, 3'd6, 1'b1);
    send_event(CMD_RECV_MRK, 2'd3, 16'd151, '0, 3'd6, 1'b0);
    send_event(CMD_RECV_MRK, 2'd0, 16'd152, {16'd0, 16'd25, 16'd50, 16'd70}, 3'd6, 1'b0);
    send_event(CMD_RECV_MRK, 2'd1, 16'd153, {16'd0, 16'd26, 16'd50, 16'd70}, 3'd6, 1'b0);
    send_event(CMD_RECV_MRK, 2'd2, 16'd154, {16'd0, 16'd26, 16'd51, 16'd70}, 3'd6, 1'b0);
    // repeated initiate
    send_event(CMD_INIT, 2'd2, '0, '0, 3'd3, 1'b1);
  endtask

  // Hold the result side off while events keep coming, so the input has to stall.
  task automatic test_receiver_backpressure();
    int n;
    sender_idle = 1'b0;
    hold_left   = PRESSURE_CYCLES;
    for (n = 0; n < 30; n++) begin
      if (n % 2 == 0)
        send_event(CMD_SEND, PEER_W'(n / 2), LAM_W'($urandom), {$urandom, $urandom}, '0, 1'b0);
      else
        send_event(CMD_RECV_XFR, PEER_W'(n / 2), near_clock(next_lam), '0, '0, 1'b1);
    end
    sender_idle = 1'b1;
  endtask

  // Random mixes under three process ids; the middle one runs without any idling.
  task automatic test_random_events();
    set_proc_id(2'd1);
    run_random(170);
    set_proc_id(2'd2);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    run_random(130);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    set_proc_id(2'd0);
    run_random(130);
  endtask

  // Use up every snapshot slot, then show that further starts are dropped.
  task automatic test_snapshot_exhaustion();
    int n;
    for (n = 0; n < SNAP_SLOTS + 2; n++)
      send_event(CMD_INIT, PEER_W'(n), LAM_W'($urandom), {$urandom, $urandom},
                 SNUM_W'(n), 1'b0);
    send_event(CMD_SEND, 2'd1, '0, '0, '0, 1'b0);
  endtask

  // Drive Lamport and every vector entry to all ones, then check that they stick.
  task automatic test_clock_saturation();
    send_event(CMD_RECV_XFR, 2'd3, '1, '1, 3'd0, 1'b1);
    send_event(CMD_SEND, 2'd2, '0, '0, '0, 1'b0);
    send_event(CMD_RECV_MRK, 2'd1, 16'h7fff, '0, 3'd4, 1'b0);
    // move our own index onto an entry that a merge already saturated
    set_proc_id(2'd3);
    send_event(CMD_SEND, 2'd0, '0, '0, '0, 1'b0);
    send_event(CMD_RECV_XFR, 2'd0, '1, '1, 3'd0, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_receiver_backpressure();
    test_random_events();
    test_snapshot_exhaustion();
    test_clock_saturation();

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("vector_clock_snapshot_tracker_top_tb: PASS");
    else
      $display("vector_clock_snapshot_tracker_top_tb: FAIL");
    $finish;
  end

endmodule
